/* rtl/cancellable_frame_timer_table_macros.svh */
// Assertion macros shared by the timer table RTL.
`ifndef CANCELLABLE_FRAME_TIMER_TABLE_MACROS_SVH
`define CANCELLABLE_FRAME_TIMER_TABLE_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define CFTT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define CFTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cftt_pkg.sv */
// Package with types and codes shared by the timer table modules.
package cftt_pkg;

   // Default table size and task id width.
   localparam int CFTT_SLOTS   = 16;
   localparam int CFTT_ID_BITS = 16;

   // Depth of the queue between the front and the back part.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Operation codes of a request.
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_CANCEL   = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_SCHEDULED = 3'd0;
   localparam logic [2:0] KIND_FIRED     = 3'd1;
   localparam logic [2:0] KIND_FULL      = 3'd2;
   localparam logic [2:0] KIND_CANCEL    = 3'd3;
   localparam logic [2:0] KIND_EXPIRED   = 3'd4;
   localparam logic [2:0] KIND_TICK_END  = 3'd5;

   // Class of a queued item, decided by the front part.
   typedef enum logic [1:0] {
      CLS_FIRE_NOW,
      CLS_SCHEDULE,
      CLS_CANCEL,
      CLS_TICK
   } item_class_type;

   // One queued item.
   typedef struct packed {
      item_class_type cls;
      logic [15:0]    delay_frames;
      logic [15:0]    cancel_id;
   } item_type;

endpackage

/* rtl/cftt_front.sv */
// Front part: accepts requests, classifies them and queues them for the back part.
module cftt_front import cftt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_delay_frames,
   input  logic [15:0] req_cancel_id,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   accept;
   logic                   push;
   logic                   known_op;
   item_type               new_item;

   // Classify the incoming transaction; an unknown operation is dropped.
   always_comb begin
      known_op              = 1'b1;
      new_item.delay_frames = req_delay_frames;
      new_item.cancel_id    = req_cancel_id;
      new_item.cls          = CLS_TICK;
      unique case (req_operation)
         OP_SCHEDULE: begin
            new_item.cls = (req_delay_frames == 16'd0) ? CLS_FIRE_NOW : CLS_SCHEDULE;
         end
         OP_CANCEL: begin
            new_item.cls = CLS_CANCEL;
         end
         OP_TICK: begin
            new_item.cls = CLS_TICK;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && known_op;

   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   // Queue pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/cftt_back.sv */
// Back part: holds the timer table, executes queued items and drives the result register.
module cftt_back import cftt_pkg::*; #(
   parameter int SLOTS   = CFTT_SLOTS,
   parameter int ID_BITS = CFTT_ID_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_task_id,
   output logic        rsp_found,
   output logic        rsp_last_of_run
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Timer storage.
   logic [ID_BITS-1:0]  id_mem  [SLOTS];
   logic [15:0]         rem_mem [SLOTS];
   logic [ID_BITS-1:0]  id_rd_ff;
   logic [15:0]         rem_rd_ff;

   state_type           state_ff, state_in;
   logic [SLOTS-1:0]    live_ff, live_in;
   logic [ID_BITS-1:0]  next_id_ff, next_id_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   item_class_type      cls_ff, cls_in;
   logic [15:0]         cid_ff, cid_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_kind_ff, rsp_kind_in;
   logic [15:0]         rsp_task_id_ff, rsp_task_id_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic [IDX_BITS-1:0] free_idx;
   logic                any_free;
   logic [IDX_BITS-1:0] rd_idx;
   logic                id_we;
   logic                rem_we;
   logic [IDX_BITS-1:0] rem_waddr;
   logic [15:0]         rem_wdata;
   logic [15:0]         rem_dec;
   logic                slot_live;
   logic                expire;
   logic                match;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Lowest free slot for a new timer.
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_idx = IDX_BITS'(i);
            any_free = 1'b1;
         end
      end
   end

   // Per-slot evaluation during a walk over the table.
   assign slot_live = live_ff[idx_ff];
   assign rem_dec   = (rem_rd_ff == 16'd0) ? 16'd0 : rem_rd_ff - 16'd1;
   assign expire    = slot_live && (rem_dec == 16'd0);
   assign match     = slot_live && (id_rd_ff == ID_BITS'(cid_ff));

   // Sequencer: executes one queued item at a time.
   always_comb begin
      state_in       = state_ff;
      live_in        = live_ff;
      next_id_in     = next_id_ff;
      idx_in         = idx_ff;
      cls_in         = cls_ff;
      cid_in         = cid_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_task_id_in = rsp_task_id_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_last_in    = rsp_last_ff;
      q_pop          = 1'b0;
      id_we          = 1'b0;
      rem_we         = 1'b0;
      rem_waddr      = free_idx;
      rem_wdata      = q_item.delay_frames;
      rd_idx         = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop        = 1'b1;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               case (q_item.cls)
                  CLS_FIRE_NOW: begin
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = KIND_FIRED;
                     rsp_task_id_in = 16'(next_id_ff);
                     next_id_in     = next_id_ff + 1'b1;
                  end
                  CLS_SCHEDULE: begin
                     rsp_valid_in = 1'b1;
                     if (any_free) begin
                        id_we              = 1'b1;
                        rem_we             = 1'b1;
                        live_in[free_idx]  = 1'b1;
                        rsp_kind_in        = KIND_SCHEDULED;
                        rsp_task_id_in     = 16'(next_id_ff);
                        next_id_in         = next_id_ff + 1'b1;
                     end else begin
                        rsp_kind_in    = KIND_FULL;
                        rsp_task_id_in = 16'd0;
                     end
                  end
                  default: begin
                     cls_in   = q_item.cls;
                     cid_in   = q_item.cancel_id;
                     hit_in   = 1'b0;
                     state_in = ST_PRIME;
                  end
               endcase
            end
         end
         ST_PRIME: begin
            rd_idx   = '0;
            idx_in   = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!(cls_ff == CLS_TICK && expire && !out_free)) begin
               rd_idx = idx_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               if (cls_ff == CLS_TICK) begin
                  if (slot_live) begin
                     rem_we    = 1'b1;
                     rem_waddr = idx_ff;
                     rem_wdata = rem_dec;
                  end
                  if (expire) begin
                     live_in[idx_ff] = 1'b0;
                     rsp_valid_in    = 1'b1;
                     rsp_kind_in     = KIND_EXPIRED;
                     rsp_task_id_in  = 16'(id_rd_ff);
                     rsp_found_in    = 1'b0;
                     rsp_last_in     = 1'b0;
                  end
               end else if (match) begin
                  live_in[idx_ff] = 1'b0;
                  hit_in          = 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (cls_ff == CLS_TICK) begin
                  rsp_kind_in    = KIND_TICK_END;
                  rsp_task_id_in = 16'd0;
                  rsp_found_in   = 1'b0;
               end else begin
                  rsp_kind_in    = KIND_CANCEL;
                  rsp_task_id_in = cid_ff;
                  rsp_found_in   = hit_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      cls_ff         <= cls_in;
      cid_ff         <= cid_in;
      hit_ff         <= hit_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_task_id_ff <= rsp_task_id_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Timer memories: one write port each, registered read at the walk address.
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[free_idx] <= next_id_ff;
      end
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      id_rd_ff  <= id_mem[rd_idx];
      rem_rd_ff <= rem_mem[rd_idx];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_task_id     = rsp_task_id_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* rtl/cancellable_frame_timer_table.sv */
// Top level of the cancellable frame timer table.
//
// Requests arrive on the req_ channel: schedule a timer, cancel a task id,
// or tick one frame. Results leave on the rsp_ channel; last_of_run marks
// the final result of each request. An unknown operation is taken and
// dropped without a result.
// A two-entry queue sits between the request front end and the executing
// back end, so requests are taken while the back end works or while a
// result waits for the receiver.
// A schedule result passes through the queue entry and the result register,
// and the back end takes one schedule per cycle while that register is free.
// A cancel or a tick goes through a prime step, a walk over the timer
// memories at one slot per cycle, and a finish step that offers the closing
// result once the result register is free.
// When rsp_stall is high the result register holds, and the walk pauses on
// the next expiring slot of a tick until the register frees.
// Reset clears all timers, the task id counter, the queue and any pending
// result; the block accepts requests in the cycle after reset.
`include "cancellable_frame_timer_table_macros.svh"

module cancellable_frame_timer_table import cftt_pkg::*; #(
   parameter int SLOTS   = CFTT_SLOTS,
   parameter int ID_BITS = CFTT_ID_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_delay_frames,
   input  logic [15:0] req_cancel_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_task_id,
   output logic        rsp_found,
   output logic        rsp_last_of_run
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Front end: accept and classify.
   cftt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_delay_frames (req_delay_frames),
      .req_cancel_id    (req_cancel_id),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // Back end: timer table and result register.
   cftt_back #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_task_id     (rsp_task_id),
      .rsp_found       (rsp_found),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // The back end never takes an item from an empty queue.
   `CFTT_ASSERT_SAME(a_pop_needs_item, clock, reset, q_pop, q_valid, "pop from empty queue")

   // Only a cancel answer reports a found timer.
   `CFTT_ASSERT_SAME(a_found_on_cancel, clock, reset, rsp_valid && rsp_found,
                     rsp_kind == KIND_CANCEL, "found set outside cancel answer")

   // Every result but an expiry closes its run.
   `CFTT_ASSERT_SAME(a_last_marks_run, clock, reset, rsp_valid,
                     rsp_last_of_run == (rsp_kind != KIND_EXPIRED),
                     "last_of_run does not match result kind")

   // A pop while the result is still waiting would lose a transaction.
   `CFTT_ASSERT_SAME(a_pop_with_room, clock, reset, q_pop, !rsp_valid || !rsp_stall,
                     "item taken while result register is blocked")

endmodule
